// ===== design/uxc_pkg.sv =====
package uxc_pkg;

    // Encoding codes held in the format registers
    localparam logic [1:0] ENC_UTF8  = 2'd0;
    localparam logic [1:0] ENC_UTF16 = 2'd1;
    localparam logic [1:0] ENC_UTF32 = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ENCODING = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ENCODING = 2'd1;

    // Reset values of the format registers
    localparam logic [1:0] SOURCE_ENCODING_RESET = ENC_UTF8;
    localparam logic [1:0] TARGET_ENCODING_RESET = ENC_UTF16;

    // Unicode constants
    localparam logic [31:0] REPLACEMENT   = 32'h0000_FFFD;
    localparam logic [31:0] MAX_SCALAR    = 32'h0010_FFFF;
    localparam logic [20:0] PLANE1_BASE   = 21'h01_0000;
    localparam logic [15:0] HIGH_SURR_LO  = 16'hD800;
    localparam logic [15:0] LOW_SURR_LO   = 16'hDC00;

    // Most target units one source item can produce
    localparam int RUN_UNITS = 4;
    localparam int RUN_IDX_W = 2;

    typedef struct packed {
        logic [31:0] unit_in;
        logic        string_end_in;
    } src_item_t;

    typedef struct packed {
        logic [31:0] unit_out;
        logic        run_last;
        logic        string_end_out;
        logic        failed;
    } dst_item_t;

    // All result units caused by one item
    typedef struct packed {
        logic [RUN_UNITS-1:0][31:0] units;
        logic [RUN_IDX_W-1:0]       last_idx;
        logic                       string_end;
        logic                       failed;
    } run_t;

endpackage

// ===== design/uxc_decode.sv =====
module uxc_decode (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [uxc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uxc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            accept,
    input  uxc_pkg::src_item_t              item,
    output logic                            push,
    output uxc_pkg::run_t                   run
);
    import uxc_pkg::*;

    logic [1:0]  src_enc_reg;
    logic [1:0]  dst_enc_reg;
    logic [1:0]  bytes_pending_reg, bytes_pending_next;
    logic [7:0]  lead_byte_reg, lead_byte_next;
    logic        first_cont_reg, first_cont_next;
    logic [20:0] acc_reg, acc_next;
    logic [9:0]  high_bits_reg, high_bits_next;
    logic        high_held_reg, high_held_next;
    logic        discarding_reg, discarding_next;

    logic        err;
    logic        have;
    logic        marker;
    logic        cont_ok;
    logic [31:0] ch;
    logic [7:0]  b;
    logic [15:0] w;
    logic [20:0] acc_shift;
    logic [20:0] fix;
    logic [20:0] v_off;
    logic        end_in;

    assign b      = item.unit_in[7:0];
    assign w      = item.unit_in[15:0];
    assign end_in = item.string_end_in;

    // Decode one source unit and work out the next decoding state
    always_comb
    begin
        bytes_pending_next = bytes_pending_reg;
        lead_byte_next     = lead_byte_reg;
        first_cont_next    = first_cont_reg;
        acc_next           = acc_reg;
        high_bits_next     = high_bits_reg;
        high_held_next     = high_held_reg;
        discarding_next    = discarding_reg;
        err       = 1'b0;
        have      = 1'b0;
        marker    = 1'b0;
        ch        = '0;
        cont_ok   = (b >= 8'h80) && (b <= 8'hBF);
        acc_shift = {acc_reg[14:0], b[5:0]};

        if (discarding_reg)
        begin
            // Drop units until the string ends, then close with a marker
            if (end_in)
            begin
                marker = 1'b1;
                discarding_next = 1'b0;
            end
        end
        else
        begin
            unique case (src_enc_reg)
                ENC_UTF8:
                begin
                    if (bytes_pending_reg == 2'd0)
                    begin
                        if (b < 8'h80)
                        begin
                            ch   = {24'd0, b};
                            have = 1'b1;
                        end
                        else if (b >= 8'hC2 && b <= 8'hDF)
                        begin
                            bytes_pending_next = 2'd1;
                            acc_next = {16'd0, b[4:0]};
                        end
                        else if (b >= 8'hE0 && b <= 8'hEF)
                        begin
                            bytes_pending_next = 2'd2;
                            acc_next = {17'd0, b[3:0]};
                        end
                        else if (b >= 8'hF0 && b <= 8'hF4)
                        begin
                            bytes_pending_next = 2'd3;
                            acc_next = {18'd0, b[2:0]};
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                        if (!err && b >= 8'h80)
                        begin
                            lead_byte_next  = b;
                            first_cont_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // Tighten the first continuation after special leads
                        if (first_cont_reg)
                        begin
                            if (lead_byte_reg == 8'hE0 && b < 8'hA0) cont_ok = 1'b0;
                            if (lead_byte_reg == 8'hED && b > 8'h9F) cont_ok = 1'b0;
                            if (lead_byte_reg == 8'hF0 && b < 8'h90) cont_ok = 1'b0;
                            if (lead_byte_reg == 8'hF4 && b > 8'h8F) cont_ok = 1'b0;
                        end
                        if (!cont_ok)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            acc_next           = acc_shift;
                            first_cont_next    = 1'b0;
                            bytes_pending_next = bytes_pending_reg - 2'd1;
                            if (bytes_pending_reg == 2'd1)
                            begin
                                ch   = {11'd0, acc_shift};
                                have = 1'b1;
                            end
                        end
                    end
                end
                ENC_UTF16:
                begin
                    if (high_held_reg)
                    begin
                        if (w >= LOW_SURR_LO && w <= 16'hDFFF)
                        begin
                            ch = {11'd0, {1'b0, high_bits_reg, w[9:0]} + PLANE1_BASE};
                            high_held_next = 1'b0;
                            have = 1'b1;
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                    else if (w >= HIGH_SURR_LO && w < LOW_SURR_LO)
                    begin
                        high_bits_next = w[9:0];
                        high_held_next = 1'b1;
                    end
                    else
                    begin
                        ch   = {16'd0, w};
                        have = 1'b1;
                    end
                end
                default:
                begin
                    // UTF-32, and the unused code, take the unit as it is
                    ch   = item.unit_in;
                    have = 1'b1;
                end
            endcase

            // Truncation: the string ends inside an open sequence
            if (!err && !have && end_in)
            begin
                err = 1'b1;
            end

            if (err)
            begin
                bytes_pending_next = '0;
                lead_byte_next     = '0;
                first_cont_next    = 1'b0;
                acc_next           = '0;
                high_bits_next     = '0;
                high_held_next     = 1'b0;
                discarding_next    = !end_in;
            end
        end

        if (marker)
        begin
            bytes_pending_next = '0;
            lead_byte_next     = '0;
            first_cont_next    = 1'b0;
            acc_next           = '0;
            high_bits_next     = '0;
            high_held_next     = 1'b0;
        end
    end

    // Encode the scalar value into target units
    always_comb
    begin
        run = '0;
        fix = ((ch >= 32'h0000_D800 && ch <= 32'h0000_DFFF) || ch > MAX_SCALAR)
            ? REPLACEMENT[20:0] : ch[20:0];
        v_off = fix - PLANE1_BASE;
        run.string_end = end_in;
        if (marker || err)
        begin
            run.failed   = 1'b1;
            run.last_idx = '0;
        end
        else if (dst_enc_reg == ENC_UTF16)
        begin
            if (fix <= 21'h00_FFFF)
            begin
                run.units[0] = {11'd0, fix};
            end
            else
            begin
                run.units[0] = {16'd0, HIGH_SURR_LO + {6'd0, v_off[19:10]}};
                run.units[1] = {16'd0, LOW_SURR_LO + {6'd0, v_off[9:0]}};
                run.last_idx = 2'd1;
            end
        end
        else if (dst_enc_reg == ENC_UTF8)
        begin
            if (fix < 21'h80)
            begin
                run.units[0] = {11'd0, fix};
            end
            else if (fix < 21'h800)
            begin
                run.units[0] = {24'd0, 3'b110, fix[10:6]};
                run.units[1] = {24'd0, 2'b10, fix[5:0]};
                run.last_idx = 2'd1;
            end
            else if (fix < 21'h1_0000)
            begin
                run.units[0] = {24'd0, 4'b1110, fix[15:12]};
                run.units[1] = {24'd0, 2'b10, fix[11:6]};
                run.units[2] = {24'd0, 2'b10, fix[5:0]};
                run.last_idx = 2'd2;
            end
            else
            begin
                run.units[0] = {24'd0, 5'b11110, fix[20:18]};
                run.units[1] = {24'd0, 2'b10, fix[17:12]};
                run.units[2] = {24'd0, 2'b10, fix[11:6]};
                run.units[3] = {24'd0, 2'b10, fix[5:0]};
                run.last_idx = 2'd3;
            end
        end
        else
        begin
            run.units[0] = ch;
        end
    end

    assign push = accept && (have || err || marker);

    // Hold format registers and decoding state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_enc_reg       <= SOURCE_ENCODING_RESET;
            dst_enc_reg       <= TARGET_ENCODING_RESET;
            bytes_pending_reg <= '0;
            lead_byte_reg     <= '0;
            first_cont_reg    <= 1'b0;
            acc_reg           <= '0;
            high_bits_reg     <= '0;
            high_held_reg     <= 1'b0;
            discarding_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SOURCE_ENCODING || cfg_index == REG_TARGET_ENCODING)
            begin
                if (cfg_index == REG_SOURCE_ENCODING)
                begin
                    src_enc_reg <= cfg_wdata;
                end
                else
                begin
                    dst_enc_reg <= cfg_wdata;
                end
                bytes_pending_reg <= '0;
                lead_byte_reg     <= '0;
                first_cont_reg    <= 1'b0;
                acc_reg           <= '0;
                high_bits_reg     <= '0;
                high_held_reg     <= 1'b0;
                discarding_reg    <= 1'b0;
            end
        end
        else if (accept)
        begin
            bytes_pending_reg <= bytes_pending_next;
            lead_byte_reg     <= lead_byte_next;
            first_cont_reg    <= first_cont_next;
            acc_reg           <= acc_next;
            high_bits_reg     <= high_bits_next;
            high_held_reg     <= high_held_next;
            discarding_reg    <= discarding_next;
        end
    end

endmodule

// ===== design/uxc_run_queue.sv =====
module uxc_run_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  uxc_pkg::run_t      run,
    output logic               src_ready,
    output logic               dst_valid,
    input  logic               dst_ready,
    output uxc_pkg::dst_item_t dst_item
);
    import uxc_pkg::*;

    run_t                 cur_reg;
    run_t                 pend_reg;
    logic                 cur_valid_reg;
    logic                 pend_valid_reg;
    logic [RUN_IDX_W-1:0] idx_reg;
    logic                 cur_last;
    logic                 cur_done;
    logic                 cur_free;

    assign cur_last  = (idx_reg == cur_reg.last_idx);
    assign cur_done  = cur_valid_reg && dst_ready && cur_last;
    assign cur_free  = !cur_valid_reg || cur_done;
    assign src_ready = !pend_valid_reg;
    assign dst_valid = cur_valid_reg;

    // Present the current unit of the active run
    always_comb
    begin
        dst_item.unit_out       = cur_reg.units[idx_reg];
        dst_item.run_last       = cur_last;
        dst_item.string_end_out = cur_reg.string_end && cur_last;
        dst_item.failed         = cur_reg.failed;
    end

    // Advance through the run, refill from the pending slot or the decoder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else if (cur_free)
        begin
            idx_reg <= '0;
            if (pend_valid_reg)
            begin
                cur_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                cur_valid_reg <= push;
            end
        end
        else
        begin
            if (dst_ready)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (push)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (cur_free)
        begin
            if (pend_valid_reg)
            begin
                cur_reg <= pend_reg;
            end
            else if (push)
            begin
                cur_reg <= run;
            end
        end
        else if (push)
        begin
            pend_reg <= run;
        end
    end

`ifndef SYNTHESIS
    a_pend_needs_cur: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> cur_valid_reg)
        else $error("pending run held while output slot empty");

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg <= cur_reg.last_idx))
        else $error("unit index beyond end of run");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !pend_valid_reg)
        else $error("run pushed while both slots full");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_ready && !dst_item.run_last)
            |=> (idx_reg == $past(idx_reg) + 1'b1))
        else $error("unit index did not advance");
`endif

endmodule

// ===== design/unicode_transcoder.sv =====
// Unicode transcoder between UTF-8, UTF-16 and UTF-32.
// src channel: one source code unit per item (src_item.unit_in) with
//   string_end_in on the final unit of a string. dst channel: one target
//   code unit per item, with run_last on the last unit caused by a source
//   item, string_end_out on the final unit of a string and failed on the
//   error result or closing marker of a malformed string.
// cfg port: cfg_we writes cfg_wdata into register cfg_index (0 source
//   encoding, 1 target encoding); any such write also clears the decoding
//   state. Write only while no item is in flight.
// Flow: an accepted item is decoded in the cycle it is accepted and its run
//   is registered into the active run slot (or the pending slot while the
//   active run is busy), so src takes one item per cycle while src_ready is
//   high; dst sends one unit per cycle while dst_ready is high; a source
//   item yields up to 4 units for UTF-8 output, 2 for UTF-16.
// A two-slot run queue sits after the decoder: src_ready drops only while
//   both the active run and one pending run are held, i.e. while dst stalls
//   or drains a multi-unit run. src_ready is a register output.
// Reset: formats return to UTF-8 in, UTF-16 out; all decoding state and
//   queued runs are cleared.
module unicode_transcoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [uxc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uxc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            src_valid,
    output logic                            src_ready,
    input  uxc_pkg::src_item_t              src_item,
    output logic                            dst_valid,
    input  logic                            dst_ready,
    output uxc_pkg::dst_item_t              dst_item
);
    import uxc_pkg::*;

    logic accept;
    logic push;
    run_t run;

    assign accept = src_valid && src_ready;

    // Decode and encode one item per cycle while src_ready is high
    uxc_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .item      (src_item),
        .push      (push),
        .run       (run)
    );

    // Queue runs and send them out one unit at a time
    uxc_run_queue u_run_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .run       (run),
        .src_ready (src_ready),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_item  (dst_item)
    );

endmodule
